[hw/rtl/wavetable_unison_oscillator_macros.svh]
// Assertion macros for the wavetable unison oscillator RTL.
// Included by files that carry concurrent checks; clock and reset are i_clk and i_rst_n.
`ifndef WAVETABLE_UNISON_OSCILLATOR_MACROS_SVH
`define WAVETABLE_UNISON_OSCILLATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define WUO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("wuo: check failed");
`define WUO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wuo: check failed");
`else
`define WUO_ASSERT(lbl, prop)
`define WUO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/wuo_pkg.sv]
// Shared types and constants of the wavetable unison oscillator.
// No dependencies; imported by the top level.
package wuo_pkg;

    localparam int WUO_TABLE_SIZE = 256;
    localparam int OSC_COUNT      = 2;

    typedef enum logic [1:0] {
        MODE_RENDER    = 2'd0,
        MODE_WRITE     = 2'd1,
        MODE_SET_OSC   = 2'd2,
        MODE_SET_LEVEL = 2'd3
    } t_mode;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_TABLE_LENGTH = 3'd0;
    localparam t_reg_idx REG_ALIASING     = 3'd1;
    localparam t_reg_idx REG_UNISON_COUNT = 3'd2;
    localparam t_reg_idx REG_UNISON_SIGN  = 3'd3;
    localparam t_reg_idx REG_VOLUME       = 3'd4;

    localparam logic [8:0]  RST_TABLE_LENGTH = 9'd64;
    localparam logic [1:0]  RST_UNISON_COUNT = 2'd1;
    localparam logic [15:0] RST_UNISON_SIGN  = 16'h7FFF;
    localparam logic [15:0] RST_VOLUME       = 16'h4000;
    localparam logic [31:0] SCALE_ONE        = 32'h4000_0000;

endpackage

[hw/rtl/wavetable_unison_oscillator.sv]
// Top level of the wavetable unison oscillator: sequencer, datapath, APB registers.
// Depends on wuo_pkg, wuo_ram and wavetable_unison_oscillator_macros.svh.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one command transaction: i_mode selects
//   render a sample, write a table entry, set an oscillator, or set the level.
//   Only a render produces an output transaction (o_valid/i_ready, o_sample).
//   Registers sit behind the APB port at byte addresses 0,4,..,16; write them idle.
//   Table writes and level sets complete on acceptance. An oscillator set runs
//   a bit-serial modulo of the phase by the table length, two reads of the
//   table's read port and an interpolation multiply.
//   A render runs, per oscillator, two bit-serial modulo passes, two table reads,
//   the interpolation and, in band-limited mode, a 24-bit restoring division of
//   the integral difference by the step (skipped when aliasing or when the
//   difference saturates), then three mix multiplies.
//   One command is processed at a time; o_ready is high while the sequencer idles.
//   The result sits in an output register, so the next command is taken while it
//   waits; a stalled receiver holds a finished render only at its final step.
//   Reset restores register defaults, clears phases, steps, levels and unit glide
//   scales. Table contents are undefined until written; no clearing pass runs.
`include "wavetable_unison_oscillator_macros.svh"
module wavetable_unison_oscillator import wuo_pkg::*; #(
    parameter int TABLE_SIZE = WUO_TABLE_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [8:0]         i_table_index,
    input  logic signed [15:0] i_table_value,
    input  logic               i_osc_select,
    input  logic [31:0]        i_phase_value,
    input  logic [31:0]        i_step_value,
    input  logic [31:0]        i_scale_value,
    input  logic [30:0]        i_level_value,
    input  logic signed [31:0] i_level_step_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_sample
);

    localparam int AW  = $clog2(TABLE_SIZE + 1);
    localparam int IW  = (AW > 9) ? AW : 9;
    localparam int LIM = (TABLE_SIZE < 256) ? TABLE_SIZE : 256;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_MOD  = 14'b00000000000010,
        ST_RDA  = 14'b00000000000100,
        ST_RDB  = 14'b00000000001000,
        ST_MUL  = 14'b00000000010000,
        ST_INT  = 14'b00000000100000,
        ST_PREP = 14'b00000001000000,
        ST_DIV  = 14'b00000010000000,
        ST_STM  = 14'b00000100000000,
        ST_STS  = 14'b00001000000000,
        ST_MIX1 = 14'b00010000000000,
        ST_MIX2 = 14'b00100000000000,
        ST_MIX3 = 14'b01000000000000,
        ST_OUT  = 14'b10000000000000
    } t_state;

    // configuration
    logic [8:0]         r_table_length;
    logic               r_aliasing;
    logic [1:0]         r_unison_count;
    logic signed [15:0] r_unison_sign;
    logic [15:0]        r_volume;

    // oscillator and voice state
    logic [31:0]        r_phase [OSC_COUNT];
    logic [31:0]        r_step  [OSC_COUNT];
    logic [31:0]        r_scale [OSC_COUNT];
    logic signed [23:0] r_prev  [OSC_COUNT];
    logic [30:0]        r_level;
    logic signed [31:0] r_level_step;

    // sequencer
    t_state             r_state;
    t_state             n_state;
    logic               r_osc;
    logic               r_render;
    logic               r_pass;
    logic [3:0]         r_mcnt;
    logic [4:0]         r_dcnt;
    logic               r_ovalid;

    // datapath
    logic [8:0]         r_mdiv;
    logic [8:0]         r_mrem;
    logic [23:0]        r_low;
    logic [7:0]         r_idx;
    logic signed [15:0] r_a;
    logic signed [41:0] r_iprod;
    logic signed [24:0] r_diff;
    logic [31:0]        r_drem;
    logic [23:0]        r_q;
    logic signed [23:0] r_x [OSC_COUNT];
    logic [63:0]        r_sprod;
    logic signed [25:0] r_m1;
    logic signed [25:0] r_m2;
    logic signed [27:0] r_m3;
    logic signed [23:0] r_sample;

    logic               in_acc;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic [8:0]         eff_len;
    logic [9:0]         m_t;
    logic [8:0]         m_rem_n;
    logic [32:0]        ph_sum;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [15:0]        ram_rdata;
    logic signed [15:0] rd_b;
    logic signed [16:0] ab_diff;
    logic signed [41:0] mul_p;
    logic signed [26:0] int_n;
    logic signed [23:0] next_i;
    logic [24:0]        mag;
    logic [32:0]        d_t;
    logic               d_bit;
    logic [31:0]        d_rem_n;
    logic [23:0]        q_n;
    logic [33:0]        step_n;
    logic signed [39:0] p1;
    logic signed [57:0] p2;
    logic signed [42:0] p3;
    logic signed [32:0] lvl_sum;
    logic               out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_sample = r_sample;
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        unique case (cfg_idx)
            REG_TABLE_LENGTH: prdata = {23'd0, r_table_length};
            REG_ALIASING:     prdata = {31'd0, r_aliasing};
            REG_UNISON_COUNT: prdata = {30'd0, r_unison_count};
            REG_UNISON_SIGN:  prdata = {16'd0, r_unison_sign};
            REG_VOLUME:       prdata = {16'd0, r_volume};
            default:          prdata = 32'd0;
        endcase
    end

    // length in use: zero acts as one, clamp to the table and phase limit
    assign eff_len = (r_table_length == 9'd0) ? 9'd1 :
                     (r_table_length > 9'(LIM)) ? 9'(LIM) : r_table_length;

    // one restoring step of the integer phase modulo
    assign m_t     = {r_mrem, r_mdiv[8]};
    assign m_rem_n = (m_t >= {1'b0, eff_len}) ? 9'(m_t - {1'b0, eff_len}) : m_t[8:0];
    assign ph_sum  = {1'b0, m_rem_n[7:0], r_low} + {1'b0, r_step[r_osc]};

    // table port
    assign ram_we    = in_acc && (t_mode'(i_mode) == MODE_WRITE)
                       && (IW'(i_table_index) <= IW'(TABLE_SIZE));
    assign ram_raddr = (r_state == ST_RDB) ? AW'({1'b0, r_idx} + 9'd1) : AW'({1'b0, r_idx});

    wuo_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_SIZE + 1)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(IW'(i_table_index))),
        .i_wdata (i_table_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // interpolation of the integral
    assign rd_b    = $signed(ram_rdata);
    assign ab_diff = 17'(rd_b) - 17'(r_a);
    assign mul_p   = ab_diff * $signed({1'b0, r_low});
    assign int_n   = 27'(r_a) * 27'sd256 + 27'(r_iprod >>> 16);
    assign next_i  = int_n[23:0];

    // difference division
    assign mag     = r_diff[24] ? 25'(-r_diff) : 25'(r_diff);
    assign d_t     = {r_drem, 1'b0};
    assign d_bit   = (d_t >= {1'b0, r_step[r_osc]});
    assign d_rem_n = d_bit ? 32'(d_t - {1'b0, r_step[r_osc]}) : d_t[31:0];
    assign q_n     = {r_q[22:0], d_bit};

    assign step_n  = r_sprod[63:30];

    // mix
    assign p1 = r_x[1] * r_unison_sign;
    assign p2 = r_m1 * $signed({1'b0, r_level});
    assign p3 = r_m2 * $signed({1'b0, r_volume});
    assign lvl_sum = $signed({2'b00, r_level}) + 33'(r_level_step);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && ((t_mode'(i_mode) == MODE_RENDER)
                               || (t_mode'(i_mode) == MODE_SET_OSC))) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (r_mcnt == 4'd0 && r_pass) begin
                    n_state = ST_RDA;
                end
            end
            ST_RDA:  n_state = ST_RDB;
            ST_RDB:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_INT;
            ST_INT:  n_state = r_render ? ST_PREP : ST_IDLE;
            ST_PREP: begin
                if (r_aliasing || r_step[r_osc] == 32'd0
                    || 32'({mag, 1'b0}) >= r_step[r_osc]) begin
                    n_state = ST_STM;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dcnt == 5'd0) begin
                    n_state = ST_STM;
                end
            end
            ST_STM:  n_state = ST_STS;
            ST_STS:  n_state = r_osc ? ST_MIX1 : ST_MOD;
            ST_MIX1: n_state = ST_MIX2;
            ST_MIX2: n_state = ST_MIX3;
            ST_MIX3: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_ovalid       <= 1'b0;
            r_table_length <= RST_TABLE_LENGTH;
            r_aliasing     <= 1'b0;
            r_unison_count <= RST_UNISON_COUNT;
            r_unison_sign  <= RST_UNISON_SIGN;
            r_volume       <= RST_VOLUME;
            for (int i = 0; i < OSC_COUNT; i++) begin
                r_phase[i] <= 32'd0;
                r_step[i]  <= 32'd0;
                r_scale[i] <= SCALE_ONE;
                r_prev[i]  <= 24'sd0;
            end
            r_level      <= 31'd0;
            r_level_step <= 32'sd0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_TABLE_LENGTH: r_table_length <= pwdata[8:0];
                    REG_ALIASING:     r_aliasing     <= pwdata[0];
                    REG_UNISON_COUNT: r_unison_count <= pwdata[1:0];
                    REG_UNISON_SIGN:  r_unison_sign  <= pwdata[15:0];
                    REG_VOLUME:       r_volume       <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (in_acc) begin
                if (t_mode'(i_mode) == MODE_SET_OSC) begin
                    r_step[i_osc_select]  <= i_step_value;
                    r_scale[i_osc_select] <= i_scale_value;
                    r_phase[i_osc_select] <= i_phase_value;
                    if (!i_osc_select && r_unison_count == 2'd1) begin
                        r_phase[1] <= i_phase_value;
                    end
                end
                if (t_mode'(i_mode) == MODE_SET_LEVEL) begin
                    r_level      <= i_level_value;
                    r_level_step <= i_level_step_value;
                end
            end
            if (r_state == ST_MOD && r_mcnt == 4'd0 && r_pass && r_render) begin
                r_phase[r_osc] <= {m_rem_n[7:0], r_low};
            end
            if (r_state == ST_INT) begin
                r_prev[r_osc] <= next_i;
                if (!r_render && !r_osc && r_unison_count == 2'd1) begin
                    r_prev[1] <= next_i;
                end
            end
            if (r_state == ST_STS) begin
                r_step[r_osc] <= (step_n[33:32] != 2'd0) ? 32'hFFFF_FFFF : step_n[31:0];
            end
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
                // ramp the level, saturate to the Q1.31 positive range
                if (lvl_sum < 0) begin
                    r_level <= 31'd0;
                end else if (lvl_sum[32:31] != 2'd0) begin
                    r_level <= 31'h7FFF_FFFF;
                end else begin
                    r_level <= lvl_sum[30:0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_osc    <= (t_mode'(i_mode) == MODE_SET_OSC) ? i_osc_select : 1'b0;
                r_render <= (t_mode'(i_mode) == MODE_RENDER);
                r_pass   <= (t_mode'(i_mode) == MODE_SET_OSC);
                r_mrem   <= 9'd0;
                r_mcnt   <= 4'd8;
                if (t_mode'(i_mode) == MODE_SET_OSC) begin
                    r_mdiv <= {1'b0, i_phase_value[31:24]};
                    r_low  <= i_phase_value[23:0];
                end else begin
                    r_mdiv <= {1'b0, r_phase[0][31:24]};
                    r_low  <= r_phase[0][23:0];
                end
            end
            ST_MOD: begin
                r_mrem <= m_rem_n;
                r_mdiv <= {r_mdiv[7:0], 1'b0};
                r_mcnt <= r_mcnt - 4'd1;
                if (r_mcnt == 4'd0) begin
                    if (!r_pass) begin
                        // advance the reduced phase by the step, reduce again
                        r_mdiv <= ph_sum[32:24];
                        r_low  <= ph_sum[23:0];
                        r_mrem <= 9'd0;
                        r_mcnt <= 4'd8;
                        r_pass <= 1'b1;
                    end else begin
                        r_idx <= m_rem_n[7:0];
                    end
                end
            end
            ST_RDB:  r_a     <= $signed(ram_rdata);
            ST_MUL:  r_iprod <= mul_p;
            ST_INT:  r_diff  <= 25'(next_i) - 25'(r_prev[r_osc]);
            ST_PREP: begin
                r_drem <= 32'(mag);
                r_q    <= 24'd0;
                r_dcnt <= 5'd23;
                if (r_aliasing) begin
                    r_x[r_osc] <= 24'(r_a) * 24'sd256;
                end else if (r_step[r_osc] == 32'd0) begin
                    r_x[r_osc] <= 24'sd0;
                end else if (r_diff[24]) begin
                    r_x[r_osc] <= -24'sd8388608;
                end else begin
                    r_x[r_osc] <= 24'sd8388607;
                end
            end
            ST_DIV: begin
                r_drem <= d_rem_n;
                r_q    <= q_n;
                r_dcnt <= r_dcnt - 5'd1;
                if (r_dcnt == 5'd0) begin
                    r_x[r_osc] <= r_diff[24] ? -$signed(q_n) : $signed(q_n);
                end
            end
            ST_STM: r_sprod <= r_step[r_osc] * r_scale[r_osc];
            ST_STS: begin
                r_osc  <= 1'b1;
                r_pass <= 1'b0;
                r_mrem <= 9'd0;
                r_mcnt <= 4'd8;
                r_mdiv <= {1'b0, r_phase[1][31:24]};
                r_low  <= r_phase[1][23:0];
            end
            ST_MIX1: r_m1 <= 26'(r_x[0]) + 26'(p1 >>> 15);
            ST_MIX2: r_m2 <= 26'(p2 >>> 31);
            ST_MIX3: r_m3 <= 28'(p3 >>> 14);
            ST_OUT: begin
                if (out_free) begin
                    if (r_m3 > 28'sd8388607) begin
                        r_sample <= 24'sd8388607;
                    end else if (r_m3 < -28'sd8388608) begin
                        r_sample <= -24'sd8388608;
                    end else begin
                        r_sample <= r_m3[23:0];
                    end
                end
            end
            default: ;
        endcase
    end

    `WUO_ASSERT(a_div_rem_below_step, (r_state == ST_DIV) |-> (r_drem < r_step[r_osc]))
    `WUO_ASSERT(a_mod_rem_below_len, (r_state == ST_MOD) |-> (r_mrem < eff_len))
    `WUO_ASSERT(a_read_in_table, (r_state == ST_RDA) |-> ({1'b0, r_idx} < eff_len))
    `WUO_ASSERT(a_table_write_idle, ram_we |-> (r_state == ST_IDLE))
    `WUO_ASSERT_NEXT(a_out_loaded, (r_state == ST_OUT) && out_free, o_valid && o_ready)

endmodule

[hw/rtl/wuo_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wuo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/tb_wavetable_unison_oscillator.sv]
// Self-checking testbench of wavetable_unison_oscillator: directed and random commands
// checked against an in-bench predictor. Depends on wuo_pkg and the RTL top level.
`timescale 1ns / 100ps
module tb_wavetable_unison_oscillator;
    import wuo_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        t_mode             mode;
        logic [8:0]        tidx;
        logic signed [15:0] tval;
        logic              osel;
        logic [31:0]       phase;
        logic [31:0]       step;
        logic [31:0]       scale;
        logic [30:0]       lvl;
        logic signed [31:0] lvl_step;
    } osc_cmd_t;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic i_valid, o_ready, o_valid, i_ready;
    logic [1:0] i_mode;
    logic [8:0] i_table_index;
    logic signed [15:0] i_table_value;
    logic i_osc_select;
    logic [31:0] i_phase_value, i_step_value, i_scale_value;
    logic [30:0] i_level_value;
    logic signed [31:0] i_level_step_value;
    logic signed [23:0] o_sample;

    wavetable_unison_oscillator dut (.*);

    // predictor state
    shortint    wave_mem [0:256];
    logic [31:0] ph [2];
    logic [31:0] stp [2];
    logic [31:0] glide [2];
    longint     last_int [2];
    longint     lvl_acc, lvl_inc;
    int         c_len, c_alias, c_ucount, c_usign, c_vol;

    logic signed [23:0] sample_q [$];
    int  mismatches = 0;
    int  samples_seen = 0;
    int  cmds_sent = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    int  stall_left = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** wavetable_unison_oscillator: FAILED **");
            $finish;
        end
    end

    // receiver stalls in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            samples_seen++;
            if (sample_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %0d", o_sample);
            end else begin
                logic signed [23:0] exp_s;
                exp_s = sample_q.pop_front();
                if (o_sample !== exp_s) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: expected %0d got %0d", exp_s, o_sample);
                end
            end
        end
    end

    function automatic longint eff_len();
        if (c_len < 1) return 1;
        if (c_len > 256) return 256;
        return c_len;
    endfunction

    function automatic longint wrap_phase(longint p);
        return p % (eff_len() << 24);
    endfunction

    function automatic longint interp_integral(longint p);
        longint idx, a, b, frac;
        idx = (p >> 24) & 'h1FFF;
        if (idx + 1 > 256) idx = 255;
        a = wave_mem[idx];
        b = wave_mem[idx + 1];
        frac = p & 'hFFFFFF;
        return a * 256 + (((b - a) * frac) >>> 16);
    endfunction

    function automatic longint advance_osc(int i);
        longint st, p, nxt, x, idx;
        logic [63:0] ns;
        st = longint'(stp[i]);
        p = wrap_phase(wrap_phase(longint'(ph[i])) + st);
        ph[i] = p[31:0];
        nxt = interp_integral(p);
        if (c_alias != 0) begin
            idx = (p >> 24) & 'h1FFF;
            if (idx > 256) idx = 256;
            x = longint'(wave_mem[idx]) * 256;
        end else if (st == 0) begin
            x = 0;
        end else begin
            x = (nxt - last_int[i]) * 16777216 / st;
            if (x < -8388608) x = -8388608;
            if (x > 8388607) x = 8388607;
        end
        last_int[i] = nxt;
        ns = (64'(stp[i]) * 64'(glide[i])) >> 30;
        stp[i] = (ns > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ns[31:0];
        return x;
    endfunction

    function automatic void load_phase(int i, logic [31:0] p);
        ph[i] = p;
        last_int[i] = interp_integral(wrap_phase(longint'(p)));
    endfunction

    function automatic void predict(osc_cmd_t c);
        longint x0, x1, mix;
        case (c.mode)
            MODE_WRITE: begin
                if (c.tidx <= 256) wave_mem[c.tidx] = c.tval;
            end
            MODE_SET_OSC: begin
                stp[c.osel] = c.step;
                glide[c.osel] = c.scale;
                load_phase(c.osel, c.phase);
                if (c.osel == 1'b0 && c_ucount == 1) load_phase(1, c.phase);
            end
            MODE_SET_LEVEL: begin
                lvl_acc = longint'(c.lvl);
                lvl_inc = longint'(c.lvl_step);
            end
            default: begin
                x0 = advance_osc(0);
                x1 = advance_osc(1);
                mix = x0 + ((x1 * c_usign) >>> 15);
                mix = (mix * lvl_acc) >>> 31;
                mix = (mix * c_vol) >>> 14;
                if (mix < -8388608) mix = -8388608;
                if (mix > 8388607) mix = 8388607;
                sample_q.push_back(mix[23:0]);
                lvl_acc = lvl_acc + lvl_inc;
                if (lvl_acc < 0) lvl_acc = 0;
                if (lvl_acc > 'h7FFFFFFF) lvl_acc = 'h7FFFFFFF;
            end
        endcase
    endfunction

    // entered and left just after a falling edge; valid stays high for back-to-back
    task automatic send_cmd(osc_cmd_t c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_mode <= c.mode;
        i_table_index <= c.tidx;
        i_table_value <= c.tval;
        i_osc_select <= c.osel;
        i_phase_value <= c.phase;
        i_step_value <= c.step;
        i_scale_value <= c.scale;
        i_level_value <= c.lvl;
        i_level_step_value <= c.lvl_step;
        i_valid <= 1'b1;
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        predict(c);
        cmds_sent++;
        @(negedge i_clk);
    endtask

    function automatic osc_cmd_t noise_cmd(t_mode m);
        osc_cmd_t c;
        c.mode = m;
        c.tidx = $urandom_range(0, 256);
        c.tval = $urandom;
        c.osel = $urandom;
        c.phase = $urandom;
        c.step = $urandom;
        c.scale = $urandom;
        c.lvl = $urandom;
        c.lvl_step = $urandom;
        return c;
    endfunction

    task automatic write_entry(int idx, int val);
        osc_cmd_t c;
        c = noise_cmd(MODE_WRITE);
        c.tidx = idx;
        c.tval = val;
        send_cmd(c);
    endtask

    task automatic set_osc(bit sel, logic [31:0] p, logic [31:0] s, logic [31:0] sc);
        osc_cmd_t c;
        c = noise_cmd(MODE_SET_OSC);
        c.osel = sel;
        c.phase = p;
        c.step = s;
        c.scale = sc;
        send_cmd(c);
    endtask

    task automatic set_level(logic [30:0] l, logic signed [31:0] ls);
        osc_cmd_t c;
        c = noise_cmd(MODE_SET_LEVEL);
        c.lvl = l;
        c.lvl_step = ls;
        send_cmd(c);
    endtask

    task automatic render();
        send_cmd(noise_cmd(MODE_RENDER));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sample_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx r, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_TABLE_LENGTH: c_len = v[8:0];
            REG_ALIASING:     c_alias = v[0];
            REG_UNISON_COUNT: c_ucount = v[1:0];
            REG_UNISON_SIGN:  c_usign = $signed(v[15:0]);
            REG_VOLUME:       c_vol = v[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(int len, int al, int uc, int us, int vol);
        wait_idle();
        reg_write(REG_TABLE_LENGTH, len);
        reg_write(REG_ALIASING, al);
        reg_write(REG_UNISON_COUNT, uc);
        reg_write(REG_UNISON_SIGN, us);
        reg_write(REG_VOLUME, vol);
    endtask

    // every entry and the guard get written before any render reads them
    task automatic test_table_fill();
        for (int i = 0; i <= 256; i++) begin
            if (i % 64 == 0) write_entry(i, -32768);
            else if (i % 64 == 32) write_entry(i, 32767);
            else write_entry(i, $urandom);
        end
        write_entry(300, 12345);   // beyond the guard: dropped
        write_entry(511, -1);
    endtask

    task automatic test_directed();
        set_level(31'h7FFF_FFFF, 32'sh8000_0000);
        set_osc(0, 32'h0, 32'h0, SCALE_ONE);    // zero step holds the phase
        render();
        set_level(31'h7FFF_FFFF, 32'sh7FFF_FFFF);
        set_osc(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // far phase, max glide
        render();
        render();
        set_osc(0, 32'h0080_0000, 32'h0000_0001, 32'h0);   // tiny step, glide to zero
        render();
        render();
        set_level(31'h0, 32'sh0100_0000);
        set_osc(0, 32'h3F00_0000, 32'h0180_0000, SCALE_ONE);
        render();
        render();
        set_level(31'h4000_0000, -32'sh0100_0000);
        render();
        render();
    endtask

    task automatic test_random(int n);
        osc_cmd_t c;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                c = noise_cmd(MODE_RENDER);
            end else if (pick < 15) begin
                c = noise_cmd(MODE_SET_OSC);
                if ($urandom_range(0, 3) != 0) begin
                    c.step = $urandom_range(1, 32'h0400_0000);
                    c.scale = SCALE_ONE + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                end
            end else if (pick < 17) begin
                c = noise_cmd(MODE_SET_LEVEL);
                if ($urandom_range(0, 1) != 0) c.lvl_step = $signed($urandom_range(0, 'hFFFF)) - 'sh8000;
            end else begin
                c = noise_cmd(MODE_WRITE);
                if ($urandom_range(0, 7) == 0) c.tidx = $urandom_range(257, 511);
            end
            send_cmd(c);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_ready = 1'b0;
        i_mode = '0; i_table_index = '0; i_table_value = '0; i_osc_select = 1'b0;
        i_phase_value = '0; i_step_value = '0; i_scale_value = '0;
        i_level_value = '0; i_level_step_value = '0;
        for (int i = 0; i <= 256; i++) wave_mem[i] = 0;
        for (int i = 0; i < 2; i++) begin
            ph[i] = '0; stp[i] = '0; glide[i] = SCALE_ONE; last_int[i] = 0;
        end
        lvl_acc = 0; lvl_inc = 0;
        c_len = RST_TABLE_LENGTH; c_alias = 0; c_ucount = RST_UNISON_COUNT;
        c_usign = $signed(RST_UNISON_SIGN); c_vol = RST_VOLUME;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_fill();
        test_directed();
        test_random(80);
        configure(1, 1, 2, -32768, 65535);
        test_directed();
        test_random(120);
        configure(256, 0, 0, 32767, 0);
        test_random(60);
        configure(0, 0, 3, -32768, 65535);
        test_random(80);
        configure(511, 1, 1, 0, 16384);
        test_random(100);
        configure($urandom_range(2, 255), 0, 1, $signed($urandom_range(0, 65535)) - 32768,
                  $urandom_range(8192, 40000));
        test_random(200);
        configure($urandom_range(1, 256), 0, 2, -20000, 30000);
        idle_on = 1'b0;
        test_random(150);

        wait_idle();
        $display("ran %0d commands, checked %0d samples across seven register settings",
                 cmds_sent, samples_seen);
        if (mismatches == 0) begin
            $display("** wavetable_unison_oscillator: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** wavetable_unison_oscillator: FAILED **");
        end
        $finish;
    end

endmodule
